>>> rtl/rpd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rpd_pkg
// Shared types and constants for the region perimeter detector: transaction
// payloads, opcodes, register indexes, controller states and the area check.
// ============================================================================
package rpd_pkg;

    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int SIZE_W     = 13;   // holds any clamped size up to 4096

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_USED     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_USED    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EIGHT_CONNECTED = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic [7:0] blue_in;
        logic [7:0] green_in;
        logic [7:0] red_in;
    } in_t;

    typedef struct packed {
        logic       is_perimeter;
        logic [7:0] out_x;
        logic [7:0] out_y;
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
    } out_t;

    // Effective area seen by the datapath, already clamped to the store size.
    typedef struct packed {
        logic [SIZE_W-1:0] w_eff;
        logic [SIZE_W-1:0] h_eff;
        logic              eight_conn;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LD_RD,
        ST_LD_WR,
        ST_Q_TOP,
        ST_Q_MID,
        ST_Q_BOT,
        ST_Q_END,
        ST_Q_OUT
    } state_t;

    function automatic logic coord_inside(logic [7:0] x, logic [7:0] y, cfg_t c);
        logic in_x;
        logic in_y;
        in_x = 16'(x) < 16'(c.w_eff);
        in_y = 16'(y) < 16'(c.h_eff);
        return in_x && in_y;
    endfunction

endpackage

>>> rtl/rpd_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// rpd_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. Read data holds while re is low.
// ============================================================================
module rpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/rpd_cfg.sv
`timescale 1ns / 1ps
// ============================================================================
// rpd_cfg
// Configuration registers. Sizes above the store limits are clamped here so
// the datapath only ever sees a usable area.
// ============================================================================
module rpd_cfg #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rpd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output rpd_pkg::cfg_t                   cfg
);

    logic [8:0] width_used_reg;
    logic [8:0] height_used_reg;
    logic       eight_conn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_used_reg  <= 9'd256;
            height_used_reg <= 9'd256;
            eight_conn_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rpd_pkg::CFG_WIDTH_USED:      width_used_reg  <= cfg_data;
                rpd_pkg::CFG_HEIGHT_USED:     height_used_reg <= cfg_data;
                rpd_pkg::CFG_EIGHT_CONNECTED: eight_conn_reg  <= cfg_data[0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        cfg.w_eff = (16'(width_used_reg) > 16'(MAX_WIDTH)) ?
                    rpd_pkg::SIZE_W'(MAX_WIDTH) : rpd_pkg::SIZE_W'(width_used_reg);
        cfg.h_eff = (16'(height_used_reg) > 16'(MAX_HEIGHT)) ?
                    rpd_pkg::SIZE_W'(MAX_HEIGHT) : rpd_pkg::SIZE_W'(height_used_reg);
        cfg.eight_conn = eight_conn_reg;
    end

endmodule

>>> rtl/region_perimeter_detect.sv
`timescale 1ns / 1ps
// ============================================================================
// region_perimeter_detect
// Perimeter test over a stored binary region mask with a colour per pixel.
// ============================================================================
//
//  Channel   Signals                         Direction  Moves
//  --------  ------------------------------  ---------  ---------------------------
//  in        in_valid, in_ready, in_data     sink       clear / load / query
//  out       out_valid, out_ready, out_data  source     one result per query
//  cfg       cfg_we, cfg_index, cfg_data     sink       register write, no wait
//
//  Steps: a load inside the area reads its mask row and writes it back; a
//  query reads the single read port of the mask RAM once per row of the
//  3x3 neighbourhood. A load outside the area and opcode 3 are taken
//  without leaving the idle state. A clear sweeps one mask row per cycle.
//  Reset: after rst_n is released the mask is swept to zero row by row,
//  during which in_ready stays low. Configuration writes are always taken.
//  Stalls: a finished result waits in the output register; the block keeps
//  accepting clears and loads meanwhile, and a query only holds in its last
//  step until the output register is free.
//
// The mask is stored as one RAM word per row (MAX_WIDTH bits wide), so a
// load is a read-modify-write of one row and a clear is a sweep over rows.
// The colours live in a second RAM addressed by y * MAX_WIDTH + x.
// ============================================================================
module region_perimeter_detect #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  rpd_pkg::in_t                    in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output rpd_pkg::out_t                   out_data,
    input  logic                            cfg_we,
    input  logic [rpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rpd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int CAW = $clog2(MAX_WIDTH * MAX_HEIGHT);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    rpd_pkg::cfg_t cfg;

    rpd_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic                 mask_we;
    logic [YW-1:0]        mask_waddr;
    logic [MAX_WIDTH-1:0] mask_wdata;
    logic                 mask_re;
    logic [YW-1:0]        mask_raddr;
    logic [MAX_WIDTH-1:0] mask_rdata;

    logic                 col_we;
    logic [CAW-1:0]       col_addr;
    logic [23:0]          col_wdata;
    logic                 col_re;
    logic [23:0]          col_rdata;

    rpd_ram #(
        .WIDTH (MAX_WIDTH),
        .DEPTH (MAX_HEIGHT)
    ) u_mask_ram (
        .clk   (clk),
        .we    (mask_we),
        .waddr (mask_waddr),
        .wdata (mask_wdata),
        .re    (mask_re),
        .raddr (mask_raddr),
        .rdata (mask_rdata)
    );

    rpd_ram #(
        .WIDTH (24),
        .DEPTH (MAX_WIDTH * MAX_HEIGHT)
    ) u_colour_ram (
        .clk   (clk),
        .we    (col_we),
        .waddr (col_addr),
        .wdata (col_wdata),
        .re    (col_re),
        .raddr (col_addr),
        .rdata (col_rdata)
    );

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    rpd_pkg::state_t state_reg, state_next;
    rpd_pkg::in_t    item_reg, item_next;
    logic [YW-1:0]   clr_row_reg, clr_row_next;
    logic [2:0]      top_bits_reg, top_bits_next;
    logic [2:0]      mid_bits_reg, mid_bits_next;
    logic [2:0]      bot_bits_reg, bot_bits_next;
    logic            out_valid_reg, out_valid_next;
    rpd_pkg::out_t   out_data_reg, out_data_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rpd_pkg::ST_CLEAR;
            clr_row_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_row_reg   <= clr_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        top_bits_reg <= top_bits_next;
        mid_bits_reg <= mid_bits_next;
        bot_bits_reg <= bot_bits_next;
        out_data_reg <= out_data_next;
    end

    // ------------------------------------------------------------------
    // Geometry of the held transaction. Neighbour coordinates are clamped
    // to the pixel itself at the area border; those reads are never used,
    // but they keep every address inside the stores.
    // ------------------------------------------------------------------
    logic          item_inside;
    logic          item_border;
    logic [15:0]   x16, y16, w16, h16;
    logic [15:0]   xl16, xr16, yt16, yb16;
    logic [XW-1:0] xl_idx, xc_idx, xr_idx;
    logic [YW-1:0] yt_row, yc_row, yb_row;
    logic [31:0]   col_addr32;
    logic          perim;

    always_comb
    begin
        x16 = 16'(item_reg.pixel_x);
        y16 = 16'(item_reg.pixel_y);
        w16 = 16'(cfg.w_eff);
        h16 = 16'(cfg.h_eff);
        item_inside = rpd_pkg::coord_inside(item_reg.pixel_x, item_reg.pixel_y, cfg);
        item_border = (x16 == 16'd0) || (y16 == 16'd0) ||
                      (x16 + 16'd1 >= w16) || (y16 + 16'd1 >= h16);

        xl16 = (x16 == 16'd0) ? x16 : x16 - 16'd1;
        xr16 = (x16 + 16'd1 >= w16) ? x16 : x16 + 16'd1;
        yt16 = (y16 == 16'd0) ? y16 : y16 - 16'd1;
        yb16 = (y16 + 16'd1 >= h16) ? y16 : y16 + 16'd1;

        if (!item_inside)
        begin
            xl16 = '0;
            xr16 = '0;
            yt16 = '0;
            yb16 = '0;
        end

        xl_idx = xl16[XW-1:0];
        xr_idx = xr16[XW-1:0];
        xc_idx = item_inside ? x16[XW-1:0] : '0;
        yt_row = yt16[YW-1:0];
        yb_row = yb16[YW-1:0];
        yc_row = item_inside ? y16[YW-1:0] : '0;

        col_addr32 = item_inside ? (y16 * 32'(MAX_WIDTH) + x16) : 32'd0;

        // Bits are ordered {left, centre, right} in each captured row.
        perim = item_inside && mid_bits_reg[1] &&
                (item_border ||
                 !mid_bits_reg[2] || !mid_bits_reg[0] ||
                 !top_bits_reg[1] || !bot_bits_reg[1] ||
                 (cfg.eight_conn &&
                  (!top_bits_reg[2] || !top_bits_reg[0] ||
                   !bot_bits_reg[2] || !bot_bits_reg[0])));
    end

    // ------------------------------------------------------------------
    // Controller: next state, memory strobes and output register.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        clr_row_next   = clr_row_reg;
        top_bits_next  = top_bits_reg;
        mid_bits_next  = mid_bits_reg;
        bot_bits_next  = bot_bits_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;

        in_ready   = 1'b0;
        mask_we    = 1'b0;
        mask_waddr = yc_row;
        mask_wdata = mask_rdata | (MAX_WIDTH'(1'b1) << xc_idx);
        mask_re    = 1'b0;
        mask_raddr = yc_row;
        col_we     = 1'b0;
        col_re     = 1'b0;
        col_addr   = col_addr32[CAW-1:0];
        col_wdata  = {item_reg.red_in, item_reg.green_in, item_reg.blue_in};

        case (state_reg)
            rpd_pkg::ST_CLEAR:
            begin
                mask_we    = 1'b1;
                mask_waddr = clr_row_reg;
                mask_wdata = '0;
                if (clr_row_reg == YW'(MAX_HEIGHT - 1))
                begin
                    clr_row_next = '0;
                    state_next   = rpd_pkg::ST_IDLE;
                end
                else
                begin
                    clr_row_next = clr_row_reg + YW'(1);
                end
            end

            rpd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next = in_data;
                    case (in_data.opcode)
                        rpd_pkg::OP_CLEAR: state_next = rpd_pkg::ST_CLEAR;
                        rpd_pkg::OP_LOAD:
                        begin
                            // Loads outside the area change nothing.
                            if (rpd_pkg::coord_inside(in_data.pixel_x, in_data.pixel_y, cfg))
                            begin
                                state_next = rpd_pkg::ST_LD_RD;
                            end
                        end
                        rpd_pkg::OP_QUERY: state_next = rpd_pkg::ST_Q_TOP;
                        default:           state_next = rpd_pkg::ST_IDLE;
                    endcase
                end
            end

            rpd_pkg::ST_LD_RD:
            begin
                mask_re    = 1'b1;
                col_we     = 1'b1;
                state_next = rpd_pkg::ST_LD_WR;
            end

            rpd_pkg::ST_LD_WR:
            begin
                mask_we    = 1'b1;
                state_next = rpd_pkg::ST_IDLE;
            end

            rpd_pkg::ST_Q_TOP:
            begin
                mask_re    = 1'b1;
                mask_raddr = yt_row;
                col_re     = 1'b1;
                state_next = rpd_pkg::ST_Q_MID;
            end

            rpd_pkg::ST_Q_MID:
            begin
                top_bits_next = {mask_rdata[xl_idx], mask_rdata[xc_idx], mask_rdata[xr_idx]};
                mask_re       = 1'b1;
                state_next    = rpd_pkg::ST_Q_BOT;
            end

            rpd_pkg::ST_Q_BOT:
            begin
                mid_bits_next = {mask_rdata[xl_idx], mask_rdata[xc_idx], mask_rdata[xr_idx]};
                mask_re       = 1'b1;
                mask_raddr    = yb_row;
                state_next    = rpd_pkg::ST_Q_END;
            end

            rpd_pkg::ST_Q_END:
            begin
                bot_bits_next = {mask_rdata[xl_idx], mask_rdata[xc_idx], mask_rdata[xr_idx]};
                state_next    = rpd_pkg::ST_Q_OUT;
            end

            rpd_pkg::ST_Q_OUT:
            begin
                // The colour RAM output still holds the entry read in the
                // first query step.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.is_perimeter = perim;
                    out_data_next.out_x        = item_reg.pixel_x;
                    out_data_next.out_y        = item_reg.pixel_y;
                    out_data_next.blue_out     = perim ? col_rdata[7:0]   : 8'd0;
                    out_data_next.green_out    = perim ? col_rdata[15:8]  : 8'd0;
                    out_data_next.red_out      = perim ? col_rdata[23:16] : 8'd0;
                    state_next                 = rpd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rpd_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
